FILE: rtl/mhpq_pkg.sv
// Shared types and constants for the max-heap priority queue.
// Used by mhpq_ctrl, mhpq_dpath and max_heap_priority_queue_top; depends on nothing.
package mhpq_pkg;

  // Default number of entries the heap can hold.
  localparam int unsigned CAPACITY_DEF = 64;

  // Fixed field widths.
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OCC_W  = 7;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

  // Source of the result value.
  localparam logic [1:0] RES_ZERO = 2'd0;
  localparam logic [1:0] RES_HELD = 2'd1;
  localparam logic [1:0] RES_READ = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load_ins;    // key <= input value, hole <= count
    logic              load_last;   // key <= last entry, hole <= root
    logic              take_result; // hold the root read for delete
    logic              inc;         // count up
    logic              dec;         // count down
    logic              rd_root;     // read root and last entry
    logic              rd_parent;   // read the parent of the hole
    logic              rd_children; // read both children of the hole
    logic              wr_key;      // write key into the hole
    logic              wr_up;       // move parent down into the hole
    logic              wr_best;     // move larger child up into the hole
    logic              emit;        // present a result beat
    logic [STAT_W-1:0] status;
    logic [1:0]        res_sel;
  } mhpq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;    // no entries held
    logic full;     // count at capacity
    logic pos_zero; // hole is at the root
    logic up_gt;    // key beats the parent just read
    logic dn_leaf;  // hole has no child
    logic dn_move;  // a child beats the key
  } mhpq_stat_t;

endpackage

FILE: rtl/mhpq_ctrl.sv
// Controller state machine for the max-heap priority queue.
// Depends on mhpq_pkg; drives mhpq_dpath through mhpq_cmd_t.
module mhpq_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mhpq_pkg::FUNC_W-1:0] in_func,
  input  mhpq_pkg::mhpq_stat_t        stat,
  output logic                        busy,
  output mhpq_pkg::mhpq_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UP_RD   = 3'd1;
  localparam logic [2:0] S_UP_CMP  = 3'd2;
  localparam logic [2:0] S_DEL_LD  = 3'd3;
  localparam logic [2:0] S_DN_RD   = 3'd4;
  localparam logic [2:0] S_DN_CMP  = 3'd5;
  localparam logic [2:0] S_PK_TAKE = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign busy = (state_r != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_func)
            mhpq_pkg::FUNC_INSERT: begin
              if (stat.full) begin
                cmd.emit   = 1'b1;
                cmd.status = mhpq_pkg::STATUS_FULL;
              end else begin
                cmd.load_ins = 1'b1;
                state_nxt    = S_UP_RD;
              end
            end
            mhpq_pkg::FUNC_DELETE: begin
              if (stat.empty) begin
                cmd.emit   = 1'b1;
                cmd.status = mhpq_pkg::STATUS_EMPTY;
              end else begin
                cmd.rd_root = 1'b1;
                state_nxt   = S_DEL_LD;
              end
            end
            mhpq_pkg::FUNC_PEEK: begin
              if (stat.empty) begin
                cmd.emit   = 1'b1;
                cmd.status = mhpq_pkg::STATUS_EMPTY;
              end else begin
                cmd.rd_root = 1'b1;
                state_nxt   = S_PK_TAKE;
              end
            end
            default: begin
              // Unused code: report the current count and change nothing.
              cmd.emit = 1'b1;
            end
          endcase
        end
      end
      S_UP_RD: begin
        if (stat.pos_zero) begin
          cmd.wr_key = 1'b1;
          cmd.inc    = 1'b1;
          cmd.emit   = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.rd_parent = 1'b1;
          state_nxt     = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.up_gt) begin
          cmd.wr_up = 1'b1;
          state_nxt = S_UP_RD;
        end else begin
          cmd.wr_key = 1'b1;
          cmd.inc    = 1'b1;
          cmd.emit   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_DEL_LD: begin
        cmd.take_result = 1'b1;
        cmd.load_last   = 1'b1;
        cmd.dec         = 1'b1;
        state_nxt       = S_DN_RD;
      end
      S_DN_RD: begin
        if (stat.dn_leaf) begin
          cmd.wr_key  = 1'b1;
          cmd.emit    = 1'b1;
          cmd.res_sel = mhpq_pkg::RES_HELD;
          state_nxt   = S_IDLE;
        end else begin
          cmd.rd_children = 1'b1;
          state_nxt       = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (stat.dn_move) begin
          cmd.wr_best = 1'b1;
          state_nxt   = S_DN_RD;
        end else begin
          cmd.wr_key  = 1'b1;
          cmd.emit    = 1'b1;
          cmd.res_sel = mhpq_pkg::RES_HELD;
          state_nxt   = S_IDLE;
        end
      end
      S_PK_TAKE: begin
        cmd.emit    = 1'b1;
        cmd.res_sel = mhpq_pkg::RES_READ;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/mhpq_dpath.sv
// Datapath for the max-heap priority queue: heap memory, hole index, key, count
// and result registers. Depends on mhpq_pkg; commanded by mhpq_ctrl.
module mhpq_dpath #(
  parameter int unsigned CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mhpq_pkg::mhpq_cmd_t                cmd,
  input  logic signed [mhpq_pkg::KEY_W-1:0]  in_value,
  output mhpq_pkg::mhpq_stat_t               stat,
  output logic                               out_valid,
  output logic signed [mhpq_pkg::KEY_W-1:0]  out_result_value,
  output logic [mhpq_pkg::STAT_W-1:0]        out_status,
  output logic [mhpq_pkg::OCC_W-1:0]         out_occupancy
);

  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W  = ADDR_W + 2;
  localparam int unsigned KEY_W  = mhpq_pkg::KEY_W;

  logic [KEY_W-1:0]        heap_mem_r [CAPACITY];
  logic [KEY_W-1:0]        rd0_r;
  logic [KEY_W-1:0]        rd1_r;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic [ADDR_W-1:0]       pos_r;
  logic [ADDR_W-1:0]       pos_nxt;
  logic signed [KEY_W-1:0] key_r;
  logic [KEY_W-1:0]        result_r;
  logic                    out_valid_r;
  logic [KEY_W-1:0]        out_result_r;
  logic [mhpq_pkg::STAT_W-1:0] out_status_r;
  logic [mhpq_pkg::OCC_W-1:0]  out_occ_r;

  logic [ADDR_W-1:0] parent_w;
  logic [IDX_W-1:0]  left_w;
  logic [IDX_W-1:0]  right_w;
  logic [IDX_W-1:0]  count_ext_w;
  logic              right_ok_w;
  logic              left_wins_w;
  logic [KEY_W-1:0]  best_val_w;
  logic              right_wins_w;
  logic [ADDR_W-1:0] best_idx_w;
  logic [KEY_W-1:0]  move_val_w;
  logic [ADDR_W-1:0] ra0_w;
  logic [ADDR_W-1:0] ra1_w;
  logic              rd_en_w;
  logic              we_w;
  logic [KEY_W-1:0]  wd_w;

  // Tree navigation around the hole.
  assign parent_w    = ADDR_W'(pos_r - 1'b1) >> 1;
  assign left_w      = IDX_W'({pos_r, 1'b1});
  assign right_w     = left_w + 1'b1;
  assign count_ext_w = IDX_W'(count_r);
  assign right_ok_w  = (right_w < count_ext_w);

  // Child selection: the right child must beat both the key and the left child.
  assign left_wins_w  = ($signed(rd0_r) > key_r);
  assign best_val_w   = left_wins_w ? rd0_r : key_r;
  assign right_wins_w = right_ok_w && ($signed(rd1_r) > $signed(best_val_w));
  assign best_idx_w   = right_wins_w ? right_w[ADDR_W-1:0] : left_w[ADDR_W-1:0];
  assign move_val_w   = right_wins_w ? rd1_r : rd0_r;

  // Status toward the controller.
  assign stat.empty    = (count_r == '0);
  assign stat.full     = (count_r >= CNT_W'(CAPACITY));
  assign stat.pos_zero = (pos_r == '0);
  assign stat.up_gt    = (key_r > $signed(rd0_r));
  assign stat.dn_leaf  = (left_w >= count_ext_w);
  assign stat.dn_move  = left_wins_w || right_wins_w;

  // Memory port selection.
  always_comb begin
    ra0_w = '0;
    ra1_w = ADDR_W'(count_r - 1'b1);
    if (cmd.rd_parent) begin
      ra0_w = parent_w;
    end else if (cmd.rd_children) begin
      ra0_w = left_w[ADDR_W-1:0];
      ra1_w = right_w[ADDR_W-1:0];
    end
  end

  assign rd_en_w = cmd.rd_root | cmd.rd_parent | cmd.rd_children;
  assign we_w    = cmd.wr_key | cmd.wr_up | cmd.wr_best;

  always_comb begin
    wd_w = key_r;
    if (cmd.wr_up) begin
      wd_w = rd0_r;
    end else if (cmd.wr_best) begin
      wd_w = move_val_w;
    end
  end

  // Heap memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (we_w) begin
      heap_mem_r[pos_r] <= wd_w;
    end
    if (rd_en_w) begin
      rd0_r <= heap_mem_r[ra0_w];
      rd1_r <= heap_mem_r[ra1_w];
    end
  end

  // Count and hole index updates.
  always_comb begin
    count_nxt = count_r;
    if (cmd.inc) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.dec) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (cmd.load_ins) begin
      pos_nxt = ADDR_W'(count_r);
    end else if (cmd.load_last) begin
      pos_nxt = '0;
    end else if (cmd.wr_up) begin
      pos_nxt = parent_w;
    end else if (cmd.wr_best) begin
      pos_nxt = best_idx_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (cmd.load_ins) begin
      key_r <= in_value;
    end else if (cmd.load_last) begin
      key_r <= $signed(rd1_r);
    end
    if (cmd.take_result) begin
      result_r <= rd0_r;
    end
  end

  // Result beat register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.res_sel)
        mhpq_pkg::RES_HELD: out_result_r <= result_r;
        mhpq_pkg::RES_READ: out_result_r <= rd0_r;
        default:            out_result_r <= '0;
      endcase
      out_status_r <= cmd.status;
      out_occ_r    <= mhpq_pkg::OCC_W'(count_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = $signed(out_result_r);
  assign out_status       = out_status_r;
  assign out_occupancy    = out_occ_r;

endmodule

FILE: rtl/max_heap_priority_queue_top.sv
// Max-heap priority queue. A full, empty or unused request is answered straight from idle;
// peek reads the root, then answers. Insert moves the hole up until the key reaches the root
// or does not beat its parent; delete moves it down until a leaf or no child beats the key.
// Each level moved (at most log2 CAPACITY) costs one memory read and one compare-and-write.
// One request at a time, taken only while busy is low; busy is already low during the strobe.
// Synchronous reset empties the heap but leaves the store as is. The receiver cannot stall.
module max_heap_priority_queue_top #(
  parameter int unsigned CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [mhpq_pkg::FUNC_W-1:0]        in_func,
  input  logic signed [mhpq_pkg::KEY_W-1:0]  in_value,
  output logic                               out_valid,
  output logic signed [mhpq_pkg::KEY_W-1:0]  out_result_value,
  output logic [mhpq_pkg::STAT_W-1:0]        out_status,
  output logic [mhpq_pkg::OCC_W-1:0]         out_occupancy
);

  mhpq_pkg::mhpq_cmd_t  cmd;
  mhpq_pkg::mhpq_stat_t stat;

  // Sequencer.
  mhpq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .stat    (stat),
    .busy    (busy),
    .cmd     (cmd)
  );

  // Heap storage and arithmetic.
  mhpq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_value         (in_value),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_occupancy    (out_occupancy)
  );

  // A result beat only shows once the sequencer is back at rest.
  a_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while sequencer busy");

  // Only one heap write per cycle.
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.wr_key, cmd.wr_up, cmd.wr_best}) <= 1)
    else $error("more than one heap write in a cycle");

  // Empty and full outcomes carry a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != mhpq_pkg::STATUS_OK) |-> (out_result_value == '0))
    else $error("error status with nonzero value");

  // An unused request answers in the next cycle.
  a_none_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == mhpq_pkg::FUNC_NONE) |=> out_valid)
    else $error("unused request not answered at once");

endmodule
